// ----- design/assert_macros.svh -----
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is low
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, masked while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- design/ssp_pkg.sv -----
package ssp_pkg;

    // Fixed port widths
    localparam int CMD_W    = 2;
    localparam int ID_PORT_W = 6;
    localparam int LIVE_W   = 7;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 7;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;

    // Command codes
    localparam t_cmd CMD_ADD    = 2'd0;
    localparam t_cmd CMD_REMOVE = 2'd1;
    localparam t_cmd CMD_NEXT   = 2'd2;
    localparam t_cmd CMD_RESET  = 2'd3;

    // Status codes
    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_FULL     = 3'd1;
    localparam t_status ST_NOT_LIVE = 3'd2;
    localparam t_status ST_RESET    = 3'd3;
    localparam t_status ST_EMPTY    = 3'd4;

endpackage

// ----- design/ssp_ram.sv -----
module ssp_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one word, read one word with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- design/ssp_modstep.sv -----
module ssp_modstep #(
    parameter int CNT_W = 7,
    parameter int K_W   = 3
) (
    input  logic [CNT_W-1:0] i_val,
    input  logic [CNT_W-1:0] i_div,
    input  logic [K_W-1:0]   i_shift,
    output logic [CNT_W-1:0] o_val
);

    localparam int W2 = 2 * CNT_W;

    logic [W2-1:0] shifted_div;
    logic [W2-1:0] wide_val;
    logic [W2-1:0] diff;

    // One restoring remainder step: subtract the shifted divisor when it fits
    always_comb begin
        shifted_div = W2'(i_div) << i_shift;
        wide_val    = W2'(i_val);
        diff        = wide_val - shifted_div;
        if (wide_val >= shifted_div) begin
            o_val = diff[CNT_W-1:0];
        end else begin
            o_val = i_val;
        end
    end

endmodule

// ----- design/sparse_set_pick_and_retire.sv -----
// Sparse set of entry ids kept as a permutation (order store) plus its inverse
// (place store), both in single-port-write RAMs with registered reads. One
// command is taken at a time; the input stalls until its result is loaded into
// the output register, which may wait on the output stall while nothing else
// runs. Steps per command: add does one RAM read, then moves any retired id
// out to the fresh slot and places the fresh id; a full add, a remove of an
// id not added and an empty next go straight to the result. Remove reads both
// stores in parallel, then writes the swap in two halves; a retired id ends
// at the check after the reads. Next uses a single compare-subtract unit that
// reduces the cursor modulo the live count one bit per cycle, then one RAM read.
// Reset (or a remove at the floor) walks one entry per cycle over the added
// entries to rewrite the identity order. Config writes are always taken.
`include "assert_macros.svh"

module sparse_set_pick_and_retire #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [ssp_pkg::CMD_W-1:0]      i_cmd,
    input  logic [ssp_pkg::ID_PORT_W-1:0]  i_entry_id,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ssp_pkg::CFG_W-1:0]      i_cfg_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [ssp_pkg::ID_PORT_W-1:0]  o_out_id,
    output logic [ssp_pkg::LIVE_W-1:0]     o_live_left,
    output logic [ssp_pkg::STATUS_W-1:0]   o_status
);

    localparam int ID_W  = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > ssp_pkg::CFG_W) ? CNT_W : ssp_pkg::CFG_W;
    localparam int K_W   = $clog2(CNT_W);
    localparam int ST_W  = 4;

    localparam logic [ST_W-1:0] S_IDLE   = 4'd0;
    localparam logic [ST_W-1:0] S_ADD_RD = 4'd1;
    localparam logic [ST_W-1:0] S_ADD_W1 = 4'd2;
    localparam logic [ST_W-1:0] S_ADD_W2 = 4'd3;
    localparam logic [ST_W-1:0] S_RM_RD  = 4'd4;
    localparam logic [ST_W-1:0] S_RM_CHK = 4'd5;
    localparam logic [ST_W-1:0] S_RM_W2  = 4'd6;
    localparam logic [ST_W-1:0] S_NX_MOD = 4'd7;
    localparam logic [ST_W-1:0] S_NX_RD  = 4'd8;
    localparam logic [ST_W-1:0] S_NX_OUT = 4'd9;
    localparam logic [ST_W-1:0] S_WALK   = 4'd10;
    localparam logic [ST_W-1:0] S_DONE   = 4'd11;

    // Control state
    logic [ST_W-1:0]            r_state, n_state;
    logic [CNT_W-1:0]           r_live, n_live;
    logic [CNT_W-1:0]           r_added, n_added;
    logic [ID_W-1:0]            r_cursor, n_cursor;
    logic [ssp_pkg::CFG_W-1:0]  r_min, n_min;
    logic                       r_out_valid, n_out_valid;

    // Working payload
    logic [ssp_pkg::ID_PORT_W-1:0] r_id, n_id;
    logic [ID_W-1:0]               r_pos, n_pos;
    logic [ID_W-1:0]               r_other, n_other;
    logic [CNT_W-1:0]              r_acc, n_acc;
    logic [K_W-1:0]                r_k, n_k;
    logic [CNT_W-1:0]              r_walk, n_walk;
    logic [ssp_pkg::ID_PORT_W-1:0] r_res_id, n_res_id;
    ssp_pkg::t_status              r_res_status, n_res_status;
    logic [ssp_pkg::ID_PORT_W-1:0] r_out_id, n_out_id;
    logic [ssp_pkg::LIVE_W-1:0]    r_out_live, n_out_live;
    ssp_pkg::t_status              r_out_status, n_out_status;

    // RAM ports
    logic            ord_we, plc_we;
    logic [ID_W-1:0] ord_waddr, ord_wdata, ord_raddr, ord_rdata;
    logic [ID_W-1:0] plc_waddr, plc_wdata, plc_raddr, plc_rdata;

    logic [CNT_W-1:0] mod_val;
    logic             at_floor;
    logic             id_unknown;

    ssp_ram #(.WIDTH(ID_W), .DEPTH(MAX_ENTRIES)) u_order (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (ord_waddr),
        .i_wdata (ord_wdata),
        .i_raddr (ord_raddr),
        .o_rdata (ord_rdata)
    );

    ssp_ram #(.WIDTH(ID_W), .DEPTH(MAX_ENTRIES)) u_place (
        .i_clk   (i_clk),
        .i_we    (plc_we),
        .i_waddr (plc_waddr),
        .i_wdata (plc_wdata),
        .i_raddr (plc_raddr),
        .o_rdata (plc_rdata)
    );

    ssp_modstep #(.CNT_W(CNT_W), .K_W(K_W)) u_modstep (
        .i_val   (r_acc),
        .i_div   (r_live),
        .i_shift (r_k),
        .o_val   (mod_val)
    );

    assign at_floor   = ((CMP_W + 1)'(r_live) <= ((CMP_W + 1)'(r_min) + (CMP_W + 1)'(1)));
    assign id_unknown = (CMP_W'(i_entry_id) >= CMP_W'(r_added));

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_id    = r_out_id;
    assign o_live_left = r_out_live;
    assign o_status    = r_out_status;

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_live       = r_live;
        n_added      = r_added;
        n_cursor     = r_cursor;
        n_min        = r_min;
        n_out_valid  = r_out_valid;
        n_id         = r_id;
        n_pos        = r_pos;
        n_other      = r_other;
        n_acc        = r_acc;
        n_k          = r_k;
        n_walk       = r_walk;
        n_res_id     = r_res_id;
        n_res_status = r_res_status;
        n_out_id     = r_out_id;
        n_out_live   = r_out_live;
        n_out_status = r_out_status;
        ord_we       = 1'b0;
        ord_waddr    = '0;
        ord_wdata    = '0;
        ord_raddr    = '0;
        plc_we       = 1'b0;
        plc_waddr    = '0;
        plc_wdata    = '0;
        plc_raddr    = '0;

        // Take a register write
        if (i_cfg_valid) begin
            n_min = i_cfg_data;
        end

        // Drop the result once it transfers
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_id         = i_entry_id;
                    n_res_id     = '0;
                    n_res_status = ssp_pkg::ST_OK;
                    n_walk       = '0;
                    case (i_cmd)
                        ssp_pkg::CMD_ADD: begin
                            if (r_added == CNT_W'(MAX_ENTRIES)) begin
                                n_res_status = ssp_pkg::ST_FULL;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_ADD_RD;
                            end
                        end
                        ssp_pkg::CMD_REMOVE: begin
                            if (at_floor) begin
                                n_res_status = ssp_pkg::ST_RESET;
                                n_state      = S_WALK;
                            end else if (id_unknown) begin
                                n_res_status = ssp_pkg::ST_NOT_LIVE;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_RM_RD;
                            end
                        end
                        ssp_pkg::CMD_NEXT: begin
                            if (r_live == '0) begin
                                n_res_status = ssp_pkg::ST_EMPTY;
                                n_state      = S_DONE;
                            end else begin
                                n_acc   = CNT_W'(r_cursor) + CNT_W'(1);
                                n_k     = K_W'(CNT_W - 1);
                                n_state = S_NX_MOD;
                            end
                        end
                        default: begin
                            n_state = S_WALK;
                        end
                    endcase
                end
            end

            // Add: fetch the id at the end of the live region
            S_ADD_RD: begin
                ord_raddr = ID_W'(r_live);
                n_state   = S_ADD_W1;
            end

            // Move a retired id out to the fresh slot
            S_ADD_W1: begin
                if (r_live != r_added) begin
                    ord_we    = 1'b1;
                    ord_waddr = ID_W'(r_added);
                    ord_wdata = ord_rdata;
                    plc_we    = 1'b1;
                    plc_waddr = ord_rdata;
                    plc_wdata = ID_W'(r_added);
                end
                n_state = S_ADD_W2;
            end

            // Place the fresh id at the end of the live region
            S_ADD_W2: begin
                ord_we    = 1'b1;
                ord_waddr = ID_W'(r_live);
                ord_wdata = ID_W'(r_added);
                plc_we    = 1'b1;
                plc_waddr = ID_W'(r_added);
                plc_wdata = ID_W'(r_live);
                n_res_id  = ssp_pkg::ID_PORT_W'(r_added);
                n_added   = r_added + CNT_W'(1);
                n_live    = r_live + CNT_W'(1);
                n_state   = S_DONE;
            end

            // Remove: look up the id's position and the last live id
            S_RM_RD: begin
                plc_raddr = ID_W'(r_id);
                ord_raddr = ID_W'(r_live - CNT_W'(1));
                n_state   = S_RM_CHK;
            end

            // Check liveness, then write the first half of the swap
            S_RM_CHK: begin
                if (CNT_W'(plc_rdata) >= r_live) begin
                    n_res_status = ssp_pkg::ST_NOT_LIVE;
                    n_state      = S_DONE;
                end else begin
                    plc_we    = 1'b1;
                    plc_waddr = ID_W'(r_id);
                    plc_wdata = ID_W'(r_live - CNT_W'(1));
                    ord_we    = 1'b1;
                    ord_waddr = plc_rdata;
                    ord_wdata = ord_rdata;
                    n_pos     = plc_rdata;
                    n_other   = ord_rdata;
                    n_state   = S_RM_W2;
                end
            end

            // Finish the swap and shrink the live region
            S_RM_W2: begin
                plc_we    = 1'b1;
                plc_waddr = r_other;
                plc_wdata = r_pos;
                ord_we    = 1'b1;
                ord_waddr = ID_W'(r_live - CNT_W'(1));
                ord_wdata = ID_W'(r_id);
                n_live    = r_live - CNT_W'(1);
                n_state   = S_DONE;
            end

            // Next: reduce the cursor modulo the live count, one bit a cycle
            S_NX_MOD: begin
                n_acc = mod_val;
                if (r_k == '0) begin
                    n_state = S_NX_RD;
                end else begin
                    n_k = r_k - K_W'(1);
                end
            end

            S_NX_RD: begin
                ord_raddr = ID_W'(r_acc);
                n_cursor  = ID_W'(r_acc);
                n_state   = S_NX_OUT;
            end

            S_NX_OUT: begin
                n_res_id = ssp_pkg::ID_PORT_W'(ord_rdata);
                n_state  = S_DONE;
            end

            // Rewrite the identity order over all added entries
            S_WALK: begin
                if (r_walk == r_added) begin
                    n_live  = r_added;
                    n_state = S_DONE;
                end else begin
                    ord_we    = 1'b1;
                    ord_waddr = ID_W'(r_walk);
                    ord_wdata = ID_W'(r_walk);
                    plc_we    = 1'b1;
                    plc_waddr = ID_W'(r_walk);
                    plc_wdata = ID_W'(r_walk);
                    n_walk    = r_walk + CNT_W'(1);
                end
            end

            // Load the output register once it is free
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_id     = r_res_id;
                    n_out_live   = ssp_pkg::LIVE_W'(r_live);
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_live      <= '0;
            r_added     <= '0;
            r_cursor    <= '0;
            r_min       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_live      <= n_live;
            r_added     <= n_added;
            r_cursor    <= n_cursor;
            r_min       <= n_min;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_id         <= n_id;
        r_pos        <= n_pos;
        r_other      <= n_other;
        r_acc        <= n_acc;
        r_k          <= n_k;
        r_walk       <= n_walk;
        r_res_id     <= n_res_id;
        r_res_status <= n_res_status;
        r_out_id     <= n_out_id;
        r_out_live   <= n_out_live;
        r_out_status <= n_out_status;
    end

    // Checks
    `ASSERT_IMPLY(a_live_within_added, i_clk, i_rst_n, 1'b1, r_live <= r_added)
    `ASSERT_IMPLY(a_added_within_max, i_clk, i_rst_n, 1'b1, r_added <= CNT_W'(MAX_ENTRIES))
    `ASSERT_NEXT(a_busy_after_transfer, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state != S_IDLE)
    `ASSERT_IMPLY(a_walk_bounded, i_clk, i_rst_n, r_state == S_WALK, r_walk <= r_added)

endmodule

// ----- sim/sparse_set_pick_and_retire_test.sv -----
`timescale 1ns / 100ps

module sparse_set_pick_and_retire_test;

    localparam int ENTRIES        = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 80;

    typedef struct packed {
        logic [ssp_pkg::ID_PORT_W-1:0] out_id;
        logic [ssp_pkg::LIVE_W-1:0]    live_left;
        ssp_pkg::t_status              status;
    } t_pick_result;

    // Track the id permutation and queue the result each command must produce
    class set_tracker;
        logic [ssp_pkg::ID_PORT_W-1:0] order_of[ENTRIES];
        logic [ssp_pkg::ID_PORT_W-1:0] place_of[ENTRIES];
        int live_n;
        int added_n;
        int cursor_pos;
        int floor_n;
        int errors;
        t_pick_result results_due[$];

        function void swap_slots(int a, int b);
            logic [ssp_pkg::ID_PORT_W-1:0] id_a;
            logic [ssp_pkg::ID_PORT_W-1:0] id_b;
            id_a = order_of[a];
            id_b = order_of[b];
            place_of[id_a] = ssp_pkg::ID_PORT_W'(b);
            place_of[id_b] = ssp_pkg::ID_PORT_W'(a);
            order_of[a] = id_b;
            order_of[b] = id_a;
        endfunction

        function void restore_order();
            for (int k = 0; k < added_n; k++) begin
                order_of[k] = ssp_pkg::ID_PORT_W'(k);
                place_of[k] = ssp_pkg::ID_PORT_W'(k);
            end
            live_n = added_n;
        endfunction

        function void note_command(ssp_pkg::t_cmd cmd, logic [ssp_pkg::ID_PORT_W-1:0] id);
            t_pick_result res;
            int fresh;
            res.out_id = '0;
            res.status = ssp_pkg::ST_OK;
            case (cmd)
                ssp_pkg::CMD_ADD: begin
                    if (added_n >= ENTRIES) begin
                        res.status = ssp_pkg::ST_FULL;
                    end else begin
                        // Append the fresh id, then swap it into the live region
                        fresh = added_n;
                        order_of[fresh] = ssp_pkg::ID_PORT_W'(fresh);
                        place_of[fresh] = ssp_pkg::ID_PORT_W'(fresh);
                        added_n++;
                        swap_slots(live_n, fresh);
                        live_n++;
                        res.out_id = ssp_pkg::ID_PORT_W'(fresh);
                    end
                end
                ssp_pkg::CMD_REMOVE: begin
                    // Floor check comes before the id check
                    if (live_n <= floor_n + 1) begin
                        restore_order();
                        res.status = ssp_pkg::ST_RESET;
                    end else if (id >= added_n || place_of[id] >= live_n) begin
                        res.status = ssp_pkg::ST_NOT_LIVE;
                    end else begin
                        swap_slots(int'(place_of[id]), live_n - 1);
                        live_n--;
                    end
                end
                ssp_pkg::CMD_NEXT: begin
                    if (live_n == 0) begin
                        res.status = ssp_pkg::ST_EMPTY;
                    end else begin
                        cursor_pos = (cursor_pos + 1) % live_n;
                        res.out_id = order_of[cursor_pos];
                    end
                end
                default: begin
                    restore_order();
                end
            endcase
            res.live_left = ssp_pkg::LIVE_W'(live_n);
            results_due.push_back(res);
        endfunction

        function void check_result(logic [ssp_pkg::ID_PORT_W-1:0] out_id,
                                   logic [ssp_pkg::LIVE_W-1:0] live_left,
                                   ssp_pkg::t_status status);
            t_pick_result want;
            if (results_due.size() == 0) begin
                $error("result transfer with nothing expected: %s %0d live_left %0d status %0d",
                       "out_id", out_id, live_left, status);
                errors++;
                return;
            end
            want = results_due.pop_front();
            if (out_id !== want.out_id) begin
                $error("out_id: expected %0d, actual %0d", want.out_id, out_id);
                errors++;
            end
            if (live_left !== want.live_left) begin
                $error("live_left: expected %0d, actual %0d", want.live_left, live_left);
                errors++;
            end
            if (status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, status);
                errors++;
            end
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    ssp_pkg::t_cmd                 i_cmd = ssp_pkg::CMD_ADD;
    logic [ssp_pkg::ID_PORT_W-1:0] i_entry_id = '0;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [ssp_pkg::CFG_W-1:0]     i_cfg_data = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic [ssp_pkg::ID_PORT_W-1:0] o_out_id;
    logic [ssp_pkg::LIVE_W-1:0]    o_live_left;
    logic [ssp_pkg::STATUS_W-1:0]  o_status;

    set_tracker tracker = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    sparse_set_pick_and_retire #(
        .MAX_ENTRIES(ENTRIES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_entry_id  (i_entry_id),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_id    (o_out_id),
        .o_live_left (o_live_left),
        .o_status    (o_status)
    );

    always #2 i_clk = ~i_clk;

    // Stall the result side at random
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Check results and watch for a hung block
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                tracker.check_result(o_out_id, o_live_left, o_status);
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Present one command, hold it until the transfer, and record the expectation
    task automatic send_command(input ssp_pkg::t_cmd cmd,
                                input logic [ssp_pkg::ID_PORT_W-1:0] id);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_entry_id <= id;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        tracker.note_command(cmd, id);
    endtask

    // Removes are the largest share, mostly of live ids; the rest are adds, nexts and resets
    task automatic send_random();
        int pick;
        ssp_pkg::t_cmd cmd;
        logic [ssp_pkg::ID_PORT_W-1:0] id;
        pick = $urandom_range(0, 99);
        id   = ssp_pkg::ID_PORT_W'($urandom_range(0, ENTRIES - 1));
        if (pick < 15) begin
            cmd = ssp_pkg::CMD_ADD;
        end else if (pick < 55) begin
            cmd = ssp_pkg::CMD_REMOVE;
            if (tracker.live_n > 0 && $urandom_range(0, 99) < 80) begin
                id = tracker.order_of[$urandom_range(0, tracker.live_n - 1)];
            end
        end else if (pick < 85) begin
            cmd = ssp_pkg::CMD_NEXT;
        end else begin
            cmd = ssp_pkg::CMD_RESET;
        end
        send_command(cmd, id);
    endtask

    task automatic wait_drained();
        while (tracker.results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Write the floor register while the block is idle
    task automatic write_floor(input int value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= ssp_pkg::CFG_W'(value);
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        tracker.floor_n = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int floor_val, input int idle_pct, input int stall_pct,
                             input int count);
        wait_drained();
        write_floor(floor_val);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_random();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait_drained();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_floor(0);

        // Directed: empty set, adds, stray and retired ids, add after removal, floor hit
        send_command(ssp_pkg::CMD_NEXT, 6'd0);
        send_command(ssp_pkg::CMD_REMOVE, 6'd63);
        send_command(ssp_pkg::CMD_RESET, 6'd0);
        send_command(ssp_pkg::CMD_ADD, 6'd63);
        send_command(ssp_pkg::CMD_ADD, 6'd0);
        send_command(ssp_pkg::CMD_ADD, 6'd21);
        send_command(ssp_pkg::CMD_ADD, 6'd42);
        send_command(ssp_pkg::CMD_NEXT, 6'd63);
        send_command(ssp_pkg::CMD_NEXT, 6'd0);
        send_command(ssp_pkg::CMD_REMOVE, 6'd63);
        send_command(ssp_pkg::CMD_REMOVE, 6'd1);
        send_command(ssp_pkg::CMD_REMOVE, 6'd1);
        send_command(ssp_pkg::CMD_ADD, 6'd0);
        send_command(ssp_pkg::CMD_NEXT, 6'd0);
        send_command(ssp_pkg::CMD_REMOVE, 6'd0);
        send_command(ssp_pkg::CMD_REMOVE, 6'd2);
        send_command(ssp_pkg::CMD_REMOVE, 6'd3);
        send_command(ssp_pkg::CMD_REMOVE, 6'd4);
        send_command(ssp_pkg::CMD_NEXT, 6'd0);
        send_command(ssp_pkg::CMD_RESET, 6'd63);
        send_command(ssp_pkg::CMD_NEXT, 6'd0);
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // Random phases across floors and idling patterns
        run_phase(0, 0, 0, 250);
        run_phase(27, 79, 0, 200);
        run_phase(64, 0, 79, 100);
        run_phase(36, 19, 19, 200);
        run_phase(2, 0, 0, 250);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.results_due.size() != 0) begin
            $error("%0d expected results never arrived", tracker.results_due.size());
            tracker.errors++;
        end
        if (tracker.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
